>>> hdl/sbrf_pkg.sv
// ----------------------------------------------------------------------------
// sbrf_pkg
// Shared types and constants for the spherical boundary restoring force block:
// payload structs, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package sbrf_pkg;

  // Field widths
  localparam int COORD_W   = 32;
  localparam int TAG_W     = 16;
  localparam int CFG_W     = 31;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Register reset values: gain 100.0, radius 1.5 (unsigned Q15.16)
  localparam logic [CFG_W-1:0] STRENGTH_RESET = 31'd6553600;
  localparam logic [CFG_W-1:0] RADIUS_RESET   = 31'd98304;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRENGTH = 2'd0,
    CFG_RADIUS   = 2'd1
  } cfg_reg_t;

  // One node position
  typedef struct packed {
    logic [TAG_W-1:0]          node_tag;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } node_t;

  // One force result
  typedef struct packed {
    logic [TAG_W-1:0]          result_tag;
    logic signed [COORD_W-1:0] force_x;
    logic signed [COORD_W-1:0] force_y;
    logic signed [COORD_W-1:0] force_z;
    logic                      zero_length;
  } result_t;

endpackage

>>> hdl/spherical_boundary_restoring_force_top.sv
// ----------------------------------------------------------------------------
// spherical_boundary_restoring_force_top
// Restoring force towards a sphere boundary: v = p - centre (last component
// clamped to <= 0), r = isqrt(|v|^2), F = strength*(R-r)*v/r, saturated.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | transfer when
//  ---------+------------------------------------------+--------------------------
//  node     | node_valid, node_ready, node             | node_valid & node_ready
//  result   | result_valid, result_ready, result       | result_valid & result_ready
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid & cfg_ready
//
//  One node per cycle sustained while the result side is not stalled. One
//  square-root bit and one quotient bit per stage set the pipeline depth.
//  Reset clears the valid bits and loads the register defaults. A stalled
//  result holds the whole pipeline; nothing is dropped.
//  cfg_ready is always high.
module spherical_boundary_restoring_force_top #(
  parameter int DIMENSIONS = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              node_valid,
  output logic                              node_ready,
  input  sbrf_pkg::node_t                   node,
  output logic                              result_valid,
  input  logic                              result_ready,
  output sbrf_pkg::result_t                 result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbrf_pkg::CFG_W-1:0]        cfg_data
);

  localparam int CW     = sbrf_pkg::COORD_W;
  localparam int TW     = sbrf_pkg::TAG_W;
  localparam int GW     = sbrf_pkg::CFG_W;
  localparam int FW     = sbrf_pkg::FRAC_W;
  localparam int MAG_W  = ((CW > GW + 1) ? CW : GW + 1) + 1;
  localparam int LO_W   = MAG_W / 2;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int SUM_W  = 2 * MAG_W + 2;
  localparam int ROOT_W = MAG_W + 1;
  localparam int MLO_W  = ROOT_W / 2;
  localparam int MHI_W  = ROOT_W - MLO_W;
  localparam int GM_W   = GW + ROOT_W;
  localparam int N_W    = GM_W + MAG_W;
  localparam int DIV_W  = ROOT_W + FW;

  typedef struct packed {
    logic                        vld;
    logic [TW-1:0]               tag;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
  } a_t;

  typedef struct packed {
    logic                        vld;
    logic [TW-1:0]               tag;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
    logic [2:0][MAG_W+LO_W-1:0]  pl;
    logic [2:0][MAG_W+HI_W-1:0]  ph;
  } b_t;

  typedef struct packed {
    logic                        vld;
    logic [TW-1:0]               tag;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
    logic [2:0][SUM_W-1:0]       sq;
  } c_t;

  typedef struct packed {
    logic                        vld;
    logic [TW-1:0]               tag;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
    logic [SUM_W-1:0]            res;
    logic [ROOT_W-1:0]           root;
  } r_t;

  typedef struct packed {
    logic                        vld;
    logic [TW-1:0]               tag;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
    logic                        zero;
    logic                        mneg;
    logic [ROOT_W-1:0]           mabs;
    logic [DIV_W-1:0]            dvs;
    logic [GW+MLO_W-1:0]         gl;
    logic [GW+MHI_W-1:0]         gh;
    logic [GM_W-1:0]             gm;
    logic [2:0][GM_W+LO_W-1:0]   nl;
    logic [2:0][GM_W+HI_W-1:0]   nh;
    logic [2:0][N_W-1:0]         rem;
    logic [2:0]                  ovf;
    logic [2:0][CW-1:0]          q;
  } p_t;

  // Configuration registers
  logic [GW-1:0] strength;
  logic [GW-1:0] radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= sbrf_pkg::STRENGTH_RESET;
      radius   <= sbrf_pkg::RADIUS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sbrf_pkg::CFG_STRENGTH: strength <= cfg_data;
        sbrf_pkg::CFG_RADIUS:   radius   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: the whole pipe moves unless the output is held
  logic advance;
  logic out_vld;
  sbrf_pkg::result_t out_data;
  sbrf_pkg::result_t out_next;

  assign advance      = !out_vld || result_ready;
  assign node_ready   = advance;
  assign result_valid = out_vld;
  assign result       = out_data;

  // Front end: centre offset, clamp and magnitudes
  logic signed [CW-1:0]  crd [3];
  logic signed [MAG_W:0] sv  [3];
  logic [MAG_W:0]        av  [3];
  a_t a, a_next;

  assign crd[0] = node.coord_x;
  assign crd[1] = node.coord_y;
  assign crd[2] = node.coord_z;

  always_comb begin
    a_next     = '0;
    a_next.vld = node_valid;
    a_next.tag = node.node_tag;
    for (int i = 0; i < 3; i++) begin
      sv[i] = {{(MAG_W + 1 - CW){crd[i][CW-1]}}, crd[i]};
      if (i == DIMENSIONS - 1) begin
        sv[i] = sv[i] - $signed({{(MAG_W + 1 - GW){1'b0}}, radius});
        if (!sv[i][MAG_W]) sv[i] = '0;
      end
      if (i >= DIMENSIONS) sv[i] = '0;
      av[i]         = sv[i][MAG_W] ? (~sv[i] + 1'b1) : sv[i];
      a_next.neg[i] = sv[i][MAG_W];
      a_next.mag[i] = av[i][MAG_W-1:0];
    end
  end

  // Squares, split into two partial products
  b_t b, b_next;
  always_comb begin
    b_next     = '0;
    b_next.vld = a.vld;
    b_next.tag = a.tag;
    b_next.neg = a.neg;
    b_next.mag = a.mag;
    for (int i = 0; i < 3; i++) begin
      b_next.pl[i] = a.mag[i] * a.mag[i][LO_W-1:0];
      b_next.ph[i] = a.mag[i] * a.mag[i][MAG_W-1:LO_W];
    end
  end

  c_t c, c_next;
  always_comb begin
    c_next     = '0;
    c_next.vld = b.vld;
    c_next.tag = b.tag;
    c_next.neg = b.neg;
    c_next.mag = b.mag;
    for (int i = 0; i < 3; i++) begin
      c_next.sq[i] = SUM_W'(b.pl[i]) + (SUM_W'(b.ph[i]) << LO_W);
    end
  end

  // Sum of squares, then one root bit per stage
  r_t sr      [ROOT_W+1];
  r_t sr_next [ROOT_W+1];

  always_comb begin
    sr_next[0]      = '0;
    sr_next[0].vld  = c.vld;
    sr_next[0].tag  = c.tag;
    sr_next[0].neg  = c.neg;
    sr_next[0].mag  = c.mag;
    sr_next[0].res  = c.sq[0] + c.sq[1] + c.sq[2];
    sr_next[0].root = '0;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - k;
    logic [SUM_W-1:0] trial;
    always_comb begin
      trial        = (SUM_W'(sr[k].root) << (B + 1)) | (SUM_W'(1) << (2 * B));
      sr_next[k+1] = sr[k];
      if (trial <= sr[k].res) begin
        sr_next[k+1].res     = sr[k].res - trial;
        sr_next[k+1].root[B] = 1'b1;
      end
    end
  end

  // Radial error and divisor
  p_t pm, pm_next;
  always_comb begin
    pm_next      = '0;
    pm_next.vld  = sr[ROOT_W].vld;
    pm_next.tag  = sr[ROOT_W].tag;
    pm_next.neg  = sr[ROOT_W].neg;
    pm_next.mag  = sr[ROOT_W].mag;
    pm_next.zero = (sr[ROOT_W].root == '0);
    pm_next.mneg = ROOT_W'(radius) < sr[ROOT_W].root;
    pm_next.mabs = pm_next.mneg ? (sr[ROOT_W].root - ROOT_W'(radius))
                                : (ROOT_W'(radius) - sr[ROOT_W].root);
    pm_next.dvs  = {sr[ROOT_W].root, {FW{1'b0}}};
  end

  // Gain times error, split on the error word
  p_t pg1, pg1_next;
  always_comb begin
    pg1_next    = pm;
    pg1_next.gl = strength * pm.mabs[MLO_W-1:0];
    pg1_next.gh = strength * pm.mabs[ROOT_W-1:MLO_W];
  end

  p_t pg2, pg2_next;
  always_comb begin
    pg2_next    = pg1;
    pg2_next.gm = GM_W'(pg1.gl) + (GM_W'(pg1.gh) << MLO_W);
  end

  // Numerator per lane, split on the magnitude
  p_t pn1, pn1_next;
  always_comb begin
    pn1_next = pg2;
    for (int i = 0; i < 3; i++) begin
      pn1_next.nl[i] = pg2.gm * pg2.mag[i][LO_W-1:0];
      pn1_next.nh[i] = pg2.gm * pg2.mag[i][MAG_W-1:LO_W];
    end
  end

  p_t pn2, pn2_next;
  always_comb begin
    pn2_next = pn1;
    for (int i = 0; i < 3; i++) begin
      pn2_next.rem[i] = N_W'(pn1.nl[i]) + (N_W'(pn1.nh[i]) << LO_W);
    end
  end

  // Quotient overflow check, then one quotient bit per stage
  p_t dv      [CW+1];
  p_t dv_next [CW+1];

  always_comb begin
    dv_next[0] = pn2;
    for (int i = 0; i < 3; i++) begin
      dv_next[0].ovf[i] = pn2.rem[i] >= (N_W'(pn2.dvs) << CW);
      dv_next[0].q[i]   = '0;
    end
  end

  for (genvar k = 0; k < CW; k++) begin : g_div
    localparam int B = CW - 1 - k;
    logic [N_W-1:0] dtrial;
    always_comb begin
      dtrial       = N_W'(dv[k].dvs) << B;
      dv_next[k+1] = dv[k];
      for (int i = 0; i < 3; i++) begin
        if (dv[k].rem[i] >= dtrial) begin
          dv_next[k+1].rem[i]  = dv[k].rem[i] - dtrial;
          dv_next[k+1].q[i][B] = 1'b1;
        end
      end
    end
  end

  // Sign, saturation and zero-length override
  logic [CW-1:0] fq  [3];
  logic [CW-1:0] fmx [3];
  logic          fng [3];
  localparam logic [CW-1:0] POS_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] NEG_MAG = {1'b1, {(CW-1){1'b0}}};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fng[i] = dv[CW].mneg ^ dv[CW].neg[i];
      if (fng[i]) begin
        fmx[i] = (dv[CW].ovf[i] || dv[CW].q[i] > NEG_MAG) ? NEG_MAG : dv[CW].q[i];
        fq[i]  = ~fmx[i] + 1'b1;
      end else begin
        fmx[i] = (dv[CW].ovf[i] || dv[CW].q[i] > POS_MAX) ? POS_MAX : dv[CW].q[i];
        fq[i]  = fmx[i];
      end
      if (dv[CW].zero) fq[i] = '0;
    end
    out_next.result_tag  = dv[CW].tag;
    out_next.force_x     = fq[0];
    out_next.force_y     = fq[1];
    out_next.force_z     = fq[2];
    out_next.zero_length = dv[CW].zero;
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a.vld   <= 1'b0;
      b.vld   <= 1'b0;
      c.vld   <= 1'b0;
      pm.vld  <= 1'b0;
      pg1.vld <= 1'b0;
      pg2.vld <= 1'b0;
      pn1.vld <= 1'b0;
      pn2.vld <= 1'b0;
      out_vld <= 1'b0;
    end else if (advance) begin
      a       <= a_next;
      b       <= b_next;
      c       <= c_next;
      pm      <= pm_next;
      pg1     <= pg1_next;
      pg2     <= pg2_next;
      pn1     <= pn1_next;
      pn2     <= pn2_next;
      out_vld <= dv[CW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= out_next;
    end
  end

  for (genvar k = 0; k <= ROOT_W; k++) begin : g_sr_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        sr[k].vld <= 1'b0;
      end else if (advance) begin
        sr[k] <= sr_next[k];
      end
    end
  end

  for (genvar k = 0; k <= CW; k++) begin : g_dv_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k].vld <= 1'b0;
      end else if (advance) begin
        dv[k] <= dv_next[k];
      end
    end
  end

endmodule

>>> tb/sv/spherical_boundary_restoring_force_top_tb.sv
// ----------------------------------------------------------------------------
// spherical_boundary_restoring_force_top_tb
// Self-checking bench for the sphere boundary restoring force block. A short
// directed table is followed by random node positions over several register
// settings. Every result transfer is checked against the directed expectation
// or a bit-exact force predictor, and both sides of the block idle and stall at random, except in one calm phase.
// ----------------------------------------------------------------------------
module spherical_boundary_restoring_force_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  DIMS         = 3;
  localparam int  PHASE_NODES  = 150;
  localparam int  DRAIN_CYCLES = 100;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam logic [sbrf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd2;  // unmapped index
  localparam logic [sbrf_pkg::CFG_W-1:0]     CFG_MAX   = 31'h7fffffff;

  typedef struct {
    sbrf_pkg::node_t   pos;
    bit                typed;
    sbrf_pkg::result_t force_exp;
  } force_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              node_valid = 1'b0;
  logic              node_ready;
  sbrf_pkg::node_t   node = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  sbrf_pkg::result_t result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [sbrf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sbrf_pkg::CFG_W-1:0]     cfg_data = '0;

  // shadow registers and expected forces
  logic [sbrf_pkg::CFG_W-1:0] gain_shadow   = sbrf_pkg::STRENGTH_RESET;
  logic [sbrf_pkg::CFG_W-1:0] radius_shadow = sbrf_pkg::RADIUS_RESET;
  sbrf_pkg::result_t force_q[$];
  bit                row_typed = 1'b0;
  sbrf_pkg::result_t row_force = '0;
  bit                calm = 1'b0;      // no idling in this phase
  int                fails = 0;
  int unsigned       cycles = 0;
  force_row_t        rows[$];

  spherical_boundary_restoring_force_top #(.DIMENSIONS(DIMS)) u_top (
    .clk, .rst, .node_valid, .node_ready, .node,
    .result_valid, .result_ready, .result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bit-exact force: F_i = strength*|R-r|*|v_i|/r >> 16, signed, saturated
  function automatic sbrf_pkg::result_t compute_force(sbrf_pkg::node_t n);
    logic signed [63:0] v[3];
    logic [63:0]        mag[3];
    logic [127:0]       sum;
    logic [127:0]       c;
    logic [127:0]       p;
    logic [63:0]        root;
    logic [63:0]        m_abs;
    logic               m_neg;
    logic               neg;
    sbrf_pkg::result_t  res;
    logic [31:0]        f[3];
    sum  = '0;
    root = '0;
    v[0] = {{32{n.coord_x[31]}}, n.coord_x};
    v[1] = {{32{n.coord_y[31]}}, n.coord_y};
    v[2] = {{32{n.coord_z[31]}}, n.coord_z};
    v[2] = v[2] - $signed({33'b0, radius_shadow});
    if (v[2] > 0) v[2] = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? 64'(-v[i]) : 64'(v[i]);
      sum    = sum + {64'b0, mag[i]} * {64'b0, mag[i]};
      f[i]   = '0;
    end
    for (int b = 52; b >= 0; b--) begin
      c = {64'b0, root | (64'd1 << b)};
      if (c * c <= sum) root = c[63:0];
    end
    res            = '0;
    res.result_tag = n.node_tag;
    if (root == 0) begin
      res.zero_length = 1'b1;
      return res;
    end
    m_neg = {33'b0, radius_shadow} < root;
    m_abs = m_neg ? root - {33'b0, radius_shadow} : {33'b0, radius_shadow} - root;
    for (int i = 0; i < 3; i++) begin
      p   = ({97'b0, gain_shadow} * {64'b0, m_abs} * {64'b0, mag[i]}) / {64'b0, root};
      p   = p >> sbrf_pkg::FRAC_W;
      neg = m_neg != (v[i] < 0);
      if (neg) f[i] = (p > 128'h8000_0000) ? 32'h8000_0000 : 32'(-p[31:0]);
      else     f[i] = (p > 128'h7fff_ffff) ? 32'h7fff_ffff : p[31:0];
    end
    res.force_x = f[0];
    res.force_y = f[1];
    res.force_z = f[2];
    return res;
  endfunction

  // Monitor: node and config transfers, result checks
  always @(posedge clk) begin
    sbrf_pkg::result_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sbrf_pkg::CFG_STRENGTH) gain_shadow <= cfg_data;
        else if (cfg_index == sbrf_pkg::CFG_RADIUS) radius_shadow <= cfg_data;
      end
      if (node_valid && node_ready)
        force_q.push_back(row_typed ? row_force : compute_force(node));
      if (result_valid && result_ready) begin
        if (force_q.size() == 0) begin
          $error("result transfer with nothing expected, tag %0h", result.result_tag);
          fails++;
        end else begin
          want = force_q.pop_front();
          if (result.result_tag !== want.result_tag) begin
            $error("result_tag: expected %0h, got %0h", want.result_tag, result.result_tag);
            fails++;
          end
          if (result.force_x !== want.force_x) begin
            $error("force_x: expected %0d, got %0d", want.force_x, result.force_x);
            fails++;
          end
          if (result.force_y !== want.force_y) begin
            $error("force_y: expected %0d, got %0d", want.force_y, result.force_y);
            fails++;
          end
          if (result.force_z !== want.force_z) begin
            $error("force_z: expected %0d, got %0d", want.force_z, result.force_z);
            fails++;
          end
          if (result.zero_length !== want.zero_length) begin
            $error("zero_length: expected %0b, got %0b", want.zero_length,
                   result.zero_length);
            fails++;
          end
        end
      end
    end
  end

  // Receiver stalls: runs of ready, occasional stalls, a few long
  initial begin
    @(negedge clk);
    forever begin
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        result_ready <= 1'b0;
        repeat (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                           : $urandom_range(10, 60)) @(negedge clk);
      end
    end
  end

  function automatic int idle_gap();
    if (calm) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
  endfunction

  // Called right after a posedge; drives on a falling edge after a random idle gap
  task automatic send_node(sbrf_pkg::node_t n, bit typed, sbrf_pkg::result_t f);
    int gap;
    gap = idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      node_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    node_valid <= 1'b1;
    node       <= n;
    row_typed  = typed;
    row_force  = f;
    @(posedge clk);
    while (!node_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (force_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write while the pipeline is empty
  task automatic write_reg(logic [sbrf_pkg::CFG_IDX_W-1:0] idx,
                           logic [sbrf_pkg::CFG_W-1:0] val);
    @(negedge clk);
    node_valid <= 1'b0;
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord(int sel);
    logic [31:0] edges[5];
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1};
    if (sel < 3) return 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
    if (sel < 5) return $urandom;
    return edges[$urandom_range(0, 4)];
  endfunction

  function automatic sbrf_pkg::node_t random_node();
    sbrf_pkg::node_t n;
    int              sel;
    sel        = $urandom_range(0, 5);
    n.node_tag = 16'($urandom);
    n.coord_x  = pick_coord(sel);
    n.coord_y  = pick_coord(sel);
    n.coord_z  = ($urandom_range(0, 15) == 0) ? 32'(radius_shadow) : pick_coord(sel);
    if ($urandom_range(0, 15) == 0) begin
      n.coord_x = '0;
      n.coord_y = '0;
    end
    return n;
  endfunction

  function automatic void add_row(logic [15:0] tag, logic [31:0] x, logic [31:0] y,
                                  logic [31:0] z, bit typed, sbrf_pkg::result_t f);
    force_row_t row;
    row.pos       = '{node_tag: tag, coord_x: x, coord_y: y, coord_z: z};
    row.typed     = typed;
    row.force_exp = f;
    rows.push_back(row);
  endfunction

  // Stimulus
  initial begin
    logic [sbrf_pkg::CFG_W-1:0] gains[5];
    logic [sbrf_pkg::CFG_W-1:0] radii[5];
    sbrf_pkg::result_t          none;
    none  = '0;
    gains = '{sbrf_pkg::STRENGTH_RESET, 31'd1, CFG_MAX, 31'd65536, 31'($urandom)};
    radii = '{sbrf_pkg::RADIUS_RESET, 31'd0, CFG_MAX, 31'd196608,
              31'($urandom_range(0, 1 << 20))};

    // centre at radius: length equals radius, so no force
    add_row(16'h0001, 32'h0, 32'h0, 32'h0, 1'b1,
            '{result_tag: 16'h0001, default: '0});
    // node exactly at the centre: zero length
    add_row(16'hffff, 32'h0, 32'h0, 32'(sbrf_pkg::RADIUS_RESET), 1'b1,
            '{result_tag: 16'hffff, zero_length: 1'b1, default: '0});
    // above the centre on the axis: last component clamped, zero length
    add_row(16'h0000, 32'h0, 32'h0, 32'h7fff_ffff, 1'b1,
            '{result_tag: 16'h0000, zero_length: 1'b1, default: '0});
    add_row(16'h1234, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, none);
    add_row(16'h8000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, none);
    add_row(16'h00ff, 32'h8000_0000, 32'h0, 32'h0, 1'b0, none);
    add_row(16'hff00, 32'h0, 32'h7fff_ffff, 32'h0, 1'b0, none);
    add_row(16'h5a5a, 32'h0, 32'h0, 32'h8000_0000, 1'b0, none);
    add_row(16'ha5a5, 32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 1'b0, none);
    add_row(16'h0002, 32'h1, 32'h0, 32'(sbrf_pkg::RADIUS_RESET), 1'b0, none);
    add_row(16'h0003, 32'hffff_ffff, 32'h1, 32'hffff_ffff, 1'b0, none);
    add_row(16'h0004, 32'h0002_0000, 32'h0, 32'h0, 1'b0, none);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_node(rows[i].pos, rows[i].typed, rows[i].force_exp);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        write_reg(sbrf_pkg::CFG_STRENGTH, gains[ph]);
        write_reg(sbrf_pkg::CFG_RADIUS, radii[ph]);
        if (ph == 3) write_reg(CFG_SPARE, 31'($urandom));  // must be ignored
      end
      calm = (ph == 2);
      repeat (PHASE_NODES) send_node(random_node(), 1'b0, none);
    end

    @(negedge clk);
    node_valid <= 1'b0;
    wait_drained();
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
